// ----- design/mbmf_pkg.sv -----
// ----------------------------------------------------------------------------
// mbmf_pkg: shared types and constants of the masked box mean filter
// input and result item layouts, configuration indexes, default sizes
// ----------------------------------------------------------------------------
package mbmf_pkg;

  localparam int unsigned DefMaxCols  = 1024;
  localparam int unsigned DefMaxHalfX = 8;
  localparam int unsigned DefMaxHalfY = 8;

  localparam int unsigned ValW  = 24;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned QuotW = 50;   // width of 4*sigma^2
  localparam int unsigned RootW = 25;

  typedef enum logic [1:0] {
    CFG_COLS  = 2'd0,
    CFG_ROWS  = 2'd1,
    CFG_WIN_X = 2'd2,
    CFG_WIN_Y = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                   mode;
    logic signed [ValW-1:0] x_offset;
    logic signed [ValW-1:0] y_offset;
    logic [ValW-1:0]        sigma_x;
    logic [ValW-1:0]        sigma_y;
    logic                   x_ok;
    logic                   y_ok;
    logic                   sigma_y_ok;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] mean_x;
    logic signed [ValW-1:0] mean_y;
    logic                   mean_ok;
    logic [ValW-1:0]        sigma_x_out;
    logic [ValW-1:0]        sigma_y_out;
    logic [8:0]             good_count;
    logic                   last;
  } out_item_t;

endpackage

// ----- design/masked_box_mean_filter.sv -----
// ----------------------------------------------------------------------------
// masked_box_mean_filter: masked window mean over a raster offset stream
// row ring buffers in two synchronous memories, window scan, shared divider
// ----------------------------------------------------------------------------
// result path: a pixel whose window completes gives its result after the
//   one-entry-per-cycle window scan of the offset memory, the bit-serial divider
//   shared by the four results and the bit-serial square root shared by the
//   two sigma results; an item whose window is not complete gives no result
// throughput: one item at a time, the next is taken once the result is gone
// reset: counters clear at once, registers load their defaults, ring memories
//   hold no reset and are only read where written in the current frame
module masked_box_mean_filter
  import mbmf_pkg::*;
#(
  parameter int unsigned MAX_COLS   = DefMaxCols,
  parameter int unsigned MAX_HALF_X = DefMaxHalfX,
  parameter int unsigned MAX_HALF_Y = DefMaxHalfY
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // input item channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  // result channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o,
  // configuration write channel
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  // ring of row buffers and derived widths
  localparam int unsigned Ring  = 2 * MAX_HALF_Y + 2;
  localparam int unsigned RW    = $clog2(Ring);
  localparam int unsigned Depth = Ring * MAX_COLS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned NW    = $clog2((2*MAX_HALF_X + 1) * (2*MAX_HALF_Y + 1) + 1);
  localparam int unsigned SW    = ValW + NW;
  localparam int unsigned OffW  = 2 * ValW + 2;
  localparam int unsigned SigW  = 2 * ValW + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_CREQ  = 4'd3;
  localparam logic [3:0] S_CCAP  = 4'd4;
  localparam logic [3:0] S_PREP  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_POST  = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_SPOST = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_q;

  // configuration registers
  logic [10:0] cols_q;
  logic [15:0] rows_q;
  logic [4:0]  win_x_q, win_y_q;

  // frame counters
  logic [CW-1:0] in_col_q, out_col_q;
  logic [16:0]   in_row_q;
  logic [15:0]   out_row_q;
  logic [RW-1:0] in_ring_q, out_ring_q;

  // ring memories
  logic [OffW-1:0] off_mem [Depth];
  logic [SigW-1:0] sig_mem [Depth];
  logic [OffW-1:0] od_q;
  logic [SigW-1:0] sd_q;
  logic [AW-1:0]   rd_addr, wr_addr;

  // window scan
  logic [RW-1:0] scan_ring_q;
  logic [CW-1:0] scan_col_q, j1_q, j2_q;
  logic [5:0]    rows_left_q;
  logic          acc_v_q;
  logic [NW-1:0] cnt_q;
  logic signed [SW-1:0] sumx_q, sumy_q;

  // arithmetic
  logic [1:0]       op_q;
  logic [5:0]       it_q;
  logic [QuotW-1:0] dq_q;
  logic [NW:0]      dr_q;
  logic [QuotW-1:0] sv_q;
  logic [26:0]      sr_q;
  logic [RootW-1:0] rt_q;

  // result registers
  logic signed [ValW-1:0] mean_x_q, mean_y_q;
  logic [ValW-1:0]        sgx_q, sgy_q;
  logic                   ok_q;

  // effective sizes
  logic [CW-1:0] nc;
  logic [15:0]   nr;
  logic [4:0]    hx, hy;

  always_comb begin
    if (cols_q == 11'd0) begin
      nc = CW'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(cols_q);
    end
    nr = (rows_q == 16'd0) ? 16'd1 : rows_q;
    hx = (32'(win_x_q >> 1) > MAX_HALF_X) ? 5'(MAX_HALF_X) : 5'(win_x_q >> 1);
    hy = (32'(win_y_q >> 1) > MAX_HALF_Y) ? 5'(MAX_HALF_Y) : 5'(win_y_q >> 1);
  end

  // window bounds for the pending output pixel
  logic [16:0]   rr;
  logic [CW:0]   cc;
  logic [15:0]   i1;
  logic [CW-1:0] j1;
  logic [RW:0]   ring_diff;
  logic [RW-1:0] ring_start;
  logic          win_ready;

  always_comb begin
    rr = 17'(out_row_q) + 17'(hy);
    if (rr > 17'(nr) - 17'd1) begin
      rr = 17'(nr) - 17'd1;
    end
    cc = (CW+1)'(out_col_q) + (CW+1)'(hx);
    if (cc > (CW+1)'(nc) - (CW+1)'(1)) begin
      cc = (CW+1)'(nc) - (CW+1)'(1);
    end
    i1 = (out_row_q > 16'(hy)) ? out_row_q - 16'(hy) : 16'd0;
    j1 = (32'(out_col_q) > 32'(hx)) ? out_col_q - CW'(hx) : CW'(0);
    ring_diff = (RW+1)'(out_ring_q) - (RW+1)'(hy);
    if (out_row_q <= 16'(hy)) begin
      ring_start = '0;
    end else if (ring_diff[RW]) begin
      ring_start = RW'(ring_diff + (RW+1)'(Ring));
    end else begin
      ring_start = RW'(ring_diff);
    end
    win_ready = (out_row_q < nr) &&
                ((in_row_q > rr) || (in_row_q == rr && (CW+1)'(in_col_q) > cc));
  end

  // handshakes
  logic in_acc, out_acc, cfg_acc, pix_wr;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign pix_wr  = in_acc && !in_data_i.mode && (in_row_q < 17'(nr));

  logic is_last;
  assign is_last = (out_row_q == nr - 16'd1) && (out_col_q == nc - CW'(1));

  // memory addressing
  assign wr_addr = AW'(in_ring_q) * AW'(MAX_COLS) + AW'(in_col_q);
  assign rd_addr = (state_q == S_SCAN)
                 ? AW'(scan_ring_q) * AW'(MAX_COLS) + AW'(scan_col_q)
                 : AW'(out_ring_q) * AW'(MAX_COLS) + AW'(out_col_q);

  always_ff @(posedge clk_i) begin
    if (pix_wr) begin
      off_mem[wr_addr] <= {in_data_i.y_ok, in_data_i.x_ok,
                           in_data_i.y_offset, in_data_i.x_offset};
      sig_mem[wr_addr] <= {in_data_i.sigma_y_ok, in_data_i.sigma_y, in_data_i.sigma_x};
    end
    od_q <= off_mem[rd_addr];
    sd_q <= sig_mem[rd_addr];
  end

  // divider and root steps
  logic [NW+1:0]   div_t;
  logic [28:0]     sq_rem;
  logic [28:0]     sq_trial;
  logic signed [SW-1:0] sel_sum;
  logic [SW-1:0]   sum_mag;
  logic [ValW-1:0] sel_sig;
  logic [ValW-1:0] qmag;
  logic [RootW:0]  m_full;

  always_comb begin
    div_t    = {dr_q, dq_q[QuotW-1]};
    sq_rem   = {sr_q, sv_q[QuotW-1 -: 2]};
    sq_trial = 29'({rt_q, 2'b01});
    sel_sum  = (op_q == 2'd0) ? sumx_q : sumy_q;
    sum_mag  = sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);
    sel_sig  = (op_q == 2'd2) ? sgx_q : sgy_q;
    qmag     = sel_sum[SW-1] ? ValW'(-dq_q[ValW-1:0]) : dq_q[ValW-1:0];
    m_full   = ((RootW+1)'(rt_q) + (RootW+1)'(1)) >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cols_q     <= 11'd1024;
      rows_q     <= 16'd1024;
      win_x_q    <= 5'd3;
      win_y_q    <= 5'd3;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
      acc_v_q    <= 1'b0;
    end else begin
      acc_v_q <= 1'b0;
      // configuration write abandons the frame
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_COLS:  cols_q  <= cfg_data_i[10:0];
          CFG_ROWS:  rows_q  <= cfg_data_i;
          CFG_WIN_X: win_x_q <= cfg_data_i[4:0];
          CFG_WIN_Y: win_y_q <= cfg_data_i[4:0];
          default:   cols_q  <= cols_q;
        endcase
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_ring_q  <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_ring_q <= '0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (pix_wr) begin
              if (in_col_q + CW'(1) >= nc) begin
                in_col_q  <= '0;
                in_row_q  <= in_row_q + 17'd1;
                in_ring_q <= (in_ring_q == RW'(Ring - 1)) ? '0 : in_ring_q + RW'(1);
              end else begin
                in_col_q <= in_col_q + CW'(1);
              end
            end
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (win_ready) begin
            scan_ring_q <= ring_start;
            scan_col_q  <= j1;
            j1_q        <= j1;
            j2_q        <= CW'(cc);
            rows_left_q <= 6'(rr - 17'(i1));
            cnt_q       <= '0;
            sumx_q      <= '0;
            sumy_q      <= '0;
            state_q     <= S_SCAN;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SCAN: begin
          acc_v_q <= 1'b1;
          if (scan_col_q == j2_q) begin
            scan_col_q  <= j1_q;
            scan_ring_q <= (scan_ring_q == RW'(Ring - 1)) ? '0 : scan_ring_q + RW'(1);
            rows_left_q <= rows_left_q - 6'd1;
            if (rows_left_q == 6'd0) begin
              state_q <= S_CREQ;
            end
          end else begin
            scan_col_q <= scan_col_q + CW'(1);
          end
        end
        S_CREQ: begin
          state_q <= S_CCAP;
        end
        S_CCAP: begin
          // centre entry and validity of the result
          sgx_q    <= sd_q[ValW-1:0];
          sgy_q    <= sd_q[2*ValW-1:ValW];
          mean_x_q <= '0;
          mean_y_q <= '0;
          ok_q     <= (cnt_q > NW'(1) || win_x_q == 5'd1 || win_y_q == 5'd1) &&
                      (cnt_q != '0) && od_q[2*ValW] && sd_q[2*ValW];
          op_q     <= 2'd0;
          if ((cnt_q > NW'(1) || win_x_q == 5'd1 || win_y_q == 5'd1) &&
              (cnt_q != '0) && od_q[2*ValW] && sd_q[2*ValW]) begin
            state_q <= S_PREP;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_PREP: begin
          // load the divider with |sum| or 4*sigma^2
          if (op_q[1]) begin
            dq_q <= {(2*ValW)'(sel_sig) * (2*ValW)'(sel_sig), 2'b00};
          end else begin
            dq_q <= QuotW'(sum_mag);
          end
          dr_q    <= '0;
          it_q    <= 6'(QuotW);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_t >= (NW+2)'(cnt_q)) begin
            dr_q <= (NW+1)'(div_t - (NW+2)'(cnt_q));
            dq_q <= {dq_q[QuotW-2:0], 1'b1};
          end else begin
            dr_q <= (NW+1)'(div_t);
            dq_q <= {dq_q[QuotW-2:0], 1'b0};
          end
          it_q <= it_q - 6'd1;
          if (it_q == 6'd1) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          if (op_q[1]) begin
            sv_q    <= dq_q;
            sr_q    <= '0;
            rt_q    <= '0;
            it_q    <= 6'(RootW);
            state_q <= S_SQRT;
          end else begin
            if (op_q == 2'd0) begin
              mean_x_q <= qmag;
            end else begin
              mean_y_q <= qmag;
            end
            op_q    <= op_q + 2'd1;
            state_q <= S_PREP;
          end
        end
        S_SQRT: begin
          // one root bit per cycle
          if (sq_rem >= sq_trial) begin
            sr_q <= 27'(sq_rem - sq_trial);
            rt_q <= {rt_q[RootW-2:0], 1'b1};
          end else begin
            sr_q <= 27'(sq_rem);
            rt_q <= {rt_q[RootW-2:0], 1'b0};
          end
          sv_q <= {sv_q[QuotW-3:0], 2'b00};
          it_q <= it_q - 6'd1;
          if (it_q == 6'd1) begin
            state_q <= S_SPOST;
          end
        end
        S_SPOST: begin
          // round half up: largest m with (2m-1)^2 <= 4s^2/n
          if (op_q == 2'd2) begin
            sgx_q   <= m_full[ValW-1:0];
            op_q    <= 2'd3;
            state_q <= S_PREP;
          end else begin
            sgy_q   <= m_full[ValW-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (is_last) begin
              in_col_q   <= '0;
              in_row_q   <= '0;
              in_ring_q  <= '0;
              out_col_q  <= '0;
              out_row_q  <= '0;
              out_ring_q <= '0;
            end else if (out_col_q + CW'(1) >= nc) begin
              out_col_q  <= '0;
              out_row_q  <= out_row_q + 16'd1;
              out_ring_q <= (out_ring_q == RW'(Ring - 1)) ? '0 : out_ring_q + RW'(1);
            end else begin
              out_col_q <= out_col_q + CW'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // accumulate the entry read in the previous cycle
      if (acc_v_q && od_q[2*ValW] && od_q[2*ValW+1]) begin
        cnt_q  <= cnt_q + NW'(1);
        sumx_q <= sumx_q + SW'($signed(od_q[ValW-1:0]));
        sumy_q <= sumy_q + SW'($signed(od_q[2*ValW-1:ValW]));
      end
    end
  end

  // result item
  always_comb begin
    out_data_o.mean_x      = mean_x_q;
    out_data_o.mean_y      = mean_y_q;
    out_data_o.mean_ok     = ok_q;
    out_data_o.sigma_x_out = sgx_q;
    out_data_o.sigma_y_out = sgy_q;
    out_data_o.good_count  = 9'(cnt_q);
    out_data_o.last        = is_last;
  end

endmodule
